[src/tcpa_pkg.sv]
// ============================================================================
// Tiered contiguous page allocator package
// Shared widths, flag layout, operation and status codes, and transaction
// types used by the allocator and its run tracker.
// ============================================================================
`timescale 1ns / 1ps

package tcpa_pkg;

  localparam int NUM_PAGES_DEF = 1024;
  localparam int CFG_W         = 11;
  localparam int IDX_W         = 10;
  localparam int FLAG_W        = 5;

  localparam logic [CFG_W-1:0] MANAGED_RESET = 11'd1024;
  localparam logic [CFG_W-1:0] CNT_MAX       = 11'd2047;

  // Bit positions inside one page map entry.
  localparam int FB_USE  = 0;
  localparam int FB_KER  = 1;
  localparam int FB_TLB  = 2;
  localparam int FB_BUSY = 3;
  localparam int FB_LAST = 4;

  localparam logic [FLAG_W-1:0] MASK_USE  = 5'b00001;
  localparam logic [FLAG_W-1:0] MASK_KER  = 5'b00010;
  localparam logic [FLAG_W-1:0] MASK_TLB  = 5'b00100;
  localparam logic [FLAG_W-1:0] MASK_BUSY = 5'b01000;
  localparam logic [FLAG_W-1:0] MASK_LAST = 5'b10000;

  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_SET   = 2'd2;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_NO_RUN   = 2'd1;
  localparam logic [1:0] STAT_BAD_FREE = 2'd2;
  localparam logic [1:0] STAT_BAD_REQ  = 2'd3;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [IDX_W-1:0] page_index;
    logic [CFG_W-1:0] page_count;
    logic             entry_in_use;
    logic             entry_kernel;
    logic             entry_tlb;
    logic             entry_busy;
  } tcpa_req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [IDX_W-1:0] start_index;
    logic [CFG_W-1:0] evicted_count;
    logic [CFG_W-1:0] free_pages;
  } tcpa_rsp_t;

  // Control from the sequencer to the run tracker.
  typedef struct packed {
    logic init;
    logic step;
    logic fin;
  } tcpa_run_ctl_t;

  // Width of page positions and run lengths: holds the page count itself and
  // is never narrower than the request count field.
  function automatic int pos_width(input int pages);
    int w;
    begin
      w = $clog2(pages) + 1;
      return (w > CFG_W) ? w : CFG_W;
    end
  endfunction

endpackage

[src/tcpa_runs.sv]
// ============================================================================
// Run tracker
// Evaluates one page map entry per step for the three eviction tiers, keeps
// the longest run of each tier, and picks the first tier that holds a request.
// ============================================================================
`timescale 1ns / 1ps

module tcpa_runs #(
  parameter int NUM_PAGES = tcpa_pkg::NUM_PAGES_DEF
) (
  input  logic                                         clk,
  input  tcpa_pkg::tcpa_run_ctl_t                      ctl,
  input  logic [tcpa_pkg::pos_width(NUM_PAGES)-1:0]    pos,
  input  logic [tcpa_pkg::FLAG_W-1:0]                  flags,
  input  logic [tcpa_pkg::CFG_W-1:0]                   need,
  output logic                                         hit,
  output logic                                         found,
  output logic [tcpa_pkg::pos_width(NUM_PAGES)-1:0]    run_start
);
  import tcpa_pkg::*;

  localparam int WW = pos_width(NUM_PAGES);
  localparam int NT = 3;

  logic [WW-1:0] cand [NT];
  logic [WW-1:0] cst  [NT];
  logic [WW-1:0] len  [NT];
  logic [WW-1:0] st   [NT];
  logic [NT-1:0] inc;
  logic [WW-1:0] need_w;

  // Tier 0 takes free pages, tier 1 also user pages outside the TLB, tier 2
  // all user pages. A busy page breaks every tier.
  always_comb begin
    inc[0] = !flags[FB_BUSY] && !flags[FB_USE];
    inc[1] = !flags[FB_BUSY] && (!flags[FB_USE] || (!flags[FB_KER] && !flags[FB_TLB]));
    inc[2] = !flags[FB_BUSY] && (!flags[FB_USE] || !flags[FB_KER]);
    need_w = WW'(need);
    hit    = ctl.step && inc[0] && ((cand[0] + WW'(1)) == need_w);
  end

  // Lowest tier wins, so walk down from the highest.
  always_comb begin
    found     = 1'b0;
    run_start = '0;
    for (int t = NT - 1; t >= 0; t--) begin
      if (len[t] >= need_w) begin
        found     = 1'b1;
        run_start = st[t];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int t = 0; t < NT; t++) begin
      if (ctl.init) begin
        cand[t] <= '0;
        cst[t]  <= '0;
        len[t]  <= '0;
        st[t]   <= '0;
      end else if (ctl.step && inc[t]) begin
        if (cand[t] == '0) begin
          cst[t] <= pos;
        end
        cand[t] <= cand[t] + WW'(1);
      end else if (ctl.step || ctl.fin) begin
        if (cand[t] > len[t]) begin
          len[t] <= cand[t];
          st[t]  <= cst[t];
        end
        cand[t] <= '0;
      end
    end
  end

endmodule

[src/tiered_contiguous_page_allocator_top.sv]
// ============================================================================
// Tiered contiguous page allocator
// Page map with in-use, kernel, TLB, busy and last-of-run flags per frame.
// One transaction is processed at a time and answered with one response.
// After reset the map is cleared, and after a write of managed_pages while
// idle or recounting the free count is rebuilt from the first M entries (M
// is the smaller of managed_pages and NUM_PAGES); no request is taken
// meanwhile. The page map sits in one memory with a single read port, and
// every pass walks it one entry per cycle. An allocate scans the managed
// entries and picks a run (the scan ends early on an exact free run), then
// claims the requested count of pages; a free checks the run up to its
// last-of-run mark and then releases it; a set-entry reads the entry and
// then writes it. The response is then loaded, which waits while the
// previous response is still held, and the next request is taken in the
// cycle after that.
// ============================================================================
`timescale 1ns / 1ps

module tiered_contiguous_page_allocator_top #(
  parameter int NUM_PAGES = tcpa_pkg::NUM_PAGES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_ready,
  input  tcpa_pkg::tcpa_req_t         req,
  output logic                        rsp_valid,
  input  logic                        rsp_ready,
  output tcpa_pkg::tcpa_rsp_t         rsp,
  input  logic                        cfg_we,
  input  logic [tcpa_pkg::CFG_W-1:0]  cfg_data
);
  import tcpa_pkg::*;

  localparam int AW = $clog2(NUM_PAGES);
  localparam int WW = pos_width(NUM_PAGES);

  typedef enum logic [3:0] {
    CLEAR, RECOUNT, IDLE, A_SCAN, A_CLOSE, A_PICK, A_WRITE,
    F_CHECK, F_RELEASE, E_READ, E_WRITE, DONE
  } state_t;

  state_t           state;
  logic [CFG_W-1:0] managed;
  logic [CFG_W-1:0] free_total;
  logic [WW-1:0]    pos;
  logic [WW-1:0]    dpos;
  logic [WW-1:0]    lim;
  logic             dv;
  tcpa_req_t        req_q;
  logic [WW-1:0]    run_st;
  logic [1:0]       res_status;
  logic [IDX_W-1:0] res_start;
  logic [CFG_W-1:0] res_evicted;

  logic [FLAG_W-1:0] mem [NUM_PAGES];
  logic [FLAG_W-1:0] rd_data;

  logic [WW-1:0]     m_eff;
  logic              issue;
  logic              page_last;
  logic              mem_we;
  logic [AW-1:0]     mem_wa;
  logic [FLAG_W-1:0] mem_wd;
  tcpa_run_ctl_t     run_ctl;
  logic              hit;
  logic              found;
  logic [WW-1:0]     run_start;

  function automatic logic [CFG_W-1:0] cnt_up(input logic [CFG_W-1:0] v);
    return (v == CNT_MAX) ? v : v + CFG_W'(1);
  endfunction

  function automatic logic [CFG_W-1:0] cnt_down(input logic [CFG_W-1:0] v);
    return (v == '0) ? v : v - CFG_W'(1);
  endfunction

  assign m_eff     = (WW'(managed) < WW'(NUM_PAGES)) ? WW'(managed) : WW'(NUM_PAGES);
  assign req_ready = (state == IDLE) && !cfg_we;
  assign page_last = (dpos + WW'(1)) == lim;

  // Read addresses run ahead by one entry; dv marks that rd_data belongs to dpos.
  always_comb begin
    unique case (state)
      RECOUNT, A_SCAN, F_CHECK: issue = pos < m_eff;
      A_WRITE, F_RELEASE:       issue = pos < lim;
      default:                  issue = 1'b0;
    endcase
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = dpos[AW-1:0];
    mem_wd = '0;
    unique case (state)
      CLEAR: begin
        mem_we = 1'b1;
        mem_wa = pos[AW-1:0];
      end
      A_WRITE: begin
        mem_we = dv;
        mem_wd = MASK_USE | MASK_KER | (page_last ? MASK_LAST : '0);
      end
      F_RELEASE: begin
        mem_we = dv;
        mem_wd = rd_data & ~(MASK_USE | MASK_KER | MASK_LAST);
      end
      E_WRITE: begin
        mem_we = 1'b1;
        mem_wa = pos[AW-1:0];
        mem_wd = (req_q.entry_in_use ? MASK_USE  : '0) |
                 (req_q.entry_kernel ? MASK_KER  : '0) |
                 (req_q.entry_tlb    ? MASK_TLB  : '0) |
                 (req_q.entry_busy   ? MASK_BUSY : '0);
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_comb begin
    run_ctl.init = req_valid && req_ready;
    run_ctl.step = (state == A_SCAN) && dv;
    run_ctl.fin  = (state == A_CLOSE);
  end

  tcpa_runs #(
    .NUM_PAGES (NUM_PAGES)
  ) u_runs (
    .clk       (clk),
    .ctl       (run_ctl),
    .pos       (dpos),
    .flags     (rd_data),
    .need      (req_q.page_count),
    .hit       (hit),
    .found     (found),
    .run_start (run_start)
  );

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data <= mem[pos[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= CLEAR;
      pos        <= '0;
      dv         <= 1'b0;
      managed    <= MANAGED_RESET;
      free_total <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      dv <= issue;
      if (issue) begin
        pos  <= pos + WW'(1);
        dpos <= pos;
      end

      unique case (state)
        CLEAR: begin
          pos <= pos + WW'(1);
          if (pos == WW'(NUM_PAGES - 1)) begin
            pos        <= '0;
            free_total <= m_eff[CFG_W-1:0];
            state      <= IDLE;
          end
        end
        RECOUNT: begin
          if (dv && !rd_data[FB_USE]) begin
            free_total <= cnt_up(free_total);
          end
          if (!issue && !dv) begin
            state <= IDLE;
          end
        end
        IDLE: begin
          if (req_valid && req_ready) begin
            req_q       <= req;
            res_status  <= STAT_OK;
            res_start   <= '0;
            res_evicted <= '0;
            pos         <= WW'(req.page_index);
            dv          <= 1'b0;
            unique case (req.opcode)
              OP_ALLOC: begin
                if (req.page_count == '0) begin
                  res_status <= STAT_BAD_REQ;
                  state      <= DONE;
                end else begin
                  pos   <= '0;
                  state <= A_SCAN;
                end
              end
              OP_FREE: begin
                if (WW'(req.page_index) < m_eff) begin
                  state <= F_CHECK;
                end else begin
                  res_status <= STAT_BAD_FREE;
                  state      <= DONE;
                end
              end
              OP_SET: begin
                if (WW'(req.page_index) < m_eff) begin
                  state <= E_READ;
                end else begin
                  res_status <= STAT_BAD_REQ;
                  state      <= DONE;
                end
              end
              default: begin
                res_status <= STAT_BAD_REQ;
                state      <= DONE;
              end
            endcase
          end
        end
        A_SCAN: begin
          // An exact free run ends the scan; the read already in flight is dropped.
          if (dv && hit) begin
            dv    <= 1'b0;
            state <= A_CLOSE;
          end else if (!issue && !dv) begin
            state <= A_CLOSE;
          end
        end
        A_CLOSE: begin
          state <= A_PICK;
        end
        A_PICK: begin
          if (found) begin
            run_st <= run_start;
            pos    <= run_start;
            lim    <= run_start + WW'(req_q.page_count);
            state  <= A_WRITE;
          end else begin
            res_status <= STAT_NO_RUN;
            state      <= DONE;
          end
        end
        A_WRITE: begin
          if (dv) begin
            if (rd_data[FB_USE]) begin
              res_evicted <= res_evicted + CFG_W'(1);
            end else begin
              free_total <= cnt_down(free_total);
            end
          end
          if (!issue && !dv) begin
            res_start <= run_st[IDX_W-1:0];
            state     <= DONE;
          end
        end
        F_CHECK: begin
          if (dv) begin
            priority if (!(rd_data[FB_USE] && rd_data[FB_KER])) begin
              dv         <= 1'b0;
              res_status <= STAT_BAD_FREE;
              state      <= DONE;
            end else if (rd_data[FB_LAST]) begin
              dv    <= 1'b0;
              lim   <= dpos + WW'(1);
              pos   <= WW'(req_q.page_index);
              state <= F_RELEASE;
            end else begin
              state <= F_CHECK;
            end
          end else if (!issue) begin
            // Walked off the managed pages without a last-of-run mark.
            res_status <= STAT_BAD_FREE;
            state      <= DONE;
          end
        end
        F_RELEASE: begin
          if (dv) begin
            free_total <= cnt_up(free_total);
          end
          if (!issue && !dv) begin
            state <= DONE;
          end
        end
        E_READ: begin
          state <= E_WRITE;
        end
        E_WRITE: begin
          if (rd_data[FB_USE] && !req_q.entry_in_use) begin
            free_total <= cnt_up(free_total);
          end else if (!rd_data[FB_USE] && req_q.entry_in_use) begin
            free_total <= cnt_down(free_total);
          end
          state <= DONE;
        end
        DONE: begin
          if (!rsp_valid || rsp_ready) begin
            rsp.status        <= res_status;
            rsp.start_index   <= res_start;
            rsp.evicted_count <= res_evicted;
            rsp.free_pages    <= free_total;
            rsp_valid         <= 1'b1;
            state             <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase

      // A new page count written while idle or recounting restarts the free page recount.
      if (cfg_we) begin
        managed <= cfg_data;
        if (state == IDLE || state == RECOUNT) begin
          pos        <= '0;
          dv         <= 1'b0;
          free_total <= '0;
          state      <= RECOUNT;
        end
      end
    end
  end

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> state != IDLE)
    else $error("accepted transaction did not start the sequencer");

  a_write_states: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == CLEAR || state == A_WRITE || state == F_RELEASE ||
                state == E_WRITE))
    else $error("page map written outside a writing pass");

  a_rsp_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state == DONE))
    else $error("response raised outside the result state");

  a_claim_in_run: assert property (@(posedge clk) disable iff (rst)
    (state == A_WRITE && mem_we) |-> dpos < lim)
    else $error("allocation wrote past the end of the chosen run");

endmodule

[verif/tiered_contiguous_page_allocator_top_tb.sv]
`timescale 1ns / 1ps
// ============================================================================
// Testbench for the tiered contiguous page allocator
// A scoreboard class keeps its own copy of the page map and free count and
// predicts every response when a request transaction is accepted. Directed
// requests cover the corner cases, then random traffic under bursty requests
// and stalling responses runs at several managed_pages settings.
// ============================================================================

module tiered_contiguous_page_allocator_top_tb;
  import tcpa_pkg::*;

  class alloc_scoreboard;
    localparam int PAGES = NUM_PAGES_DEF;

    logic [FLAG_W-1:0] flags [PAGES];
    int unsigned       free_cnt;
    int unsigned       managed;
    int unsigned       run_len [3];
    int unsigned       run_st [3];
    int unsigned       run_cand [3];
    tcpa_rsp_t         pending_rsp [$];
    int                errors;
    int                n_checked;
    int                n_alloc_ok;
    int                n_evicted;
    int                n_free_ok;
    int                n_refused;

    function new();
      foreach (flags[i]) flags[i] = '0;
      managed    = MANAGED_RESET;
      errors     = 0;
      n_checked  = 0;
      n_alloc_ok = 0;
      n_evicted  = 0;
      n_free_ok  = 0;
      n_refused  = 0;
      recount();
    endfunction

    function int unsigned span();
      return (managed < PAGES) ? managed : PAGES;
    endfunction

    function void recount();
      int unsigned n;
      n = 0;
      for (int i = 0; i < span(); i++)
        if (!flags[i][FB_USE]) n++;
      free_cnt = (n > CNT_MAX) ? CNT_MAX : n;
    endfunction

    function void bump_free();
      if (free_cnt < CNT_MAX) free_cnt++;
    endfunction

    function void drop_free();
      if (free_cnt > 0) free_cnt--;
    endfunction

    function void configure(logic [CFG_W-1:0] v);
      managed = v;
      recount();
    endfunction

    // Ends the current candidate run of one tier at position at.
    function void close_run(int t, int unsigned at);
      if (run_cand[t] > run_len[t]) begin
        run_len[t] = run_cand[t];
        run_st[t]  = at - run_cand[t];
      end
      run_cand[t] = 0;
    endfunction

    function logic [1:0] claim_run(int unsigned need, output int unsigned first,
                                   output int unsigned evicted);
      int unsigned       m;
      int unsigned       i;
      int unsigned       j;
      int                t;
      bit                stop;
      logic [FLAG_W-1:0] f;
      m       = span();
      first   = 0;
      evicted = 0;
      if (need == 0) return STAT_BAD_REQ;
      for (t = 0; t < 3; t++) begin
        run_len[t]  = 0;
        run_st[t]   = 0;
        run_cand[t] = 0;
      end
      i    = 0;
      stop = 0;
      while (i < m && !stop) begin
        f = flags[i];
        if (f[FB_BUSY]) begin
          for (t = 0; t < 3; t++) close_run(t, i);
        end else if (!f[FB_USE]) begin
          for (t = 0; t < 3; t++) run_cand[t]++;
        end else begin
          close_run(0, i);
          if (!f[FB_KER]) begin
            if (!f[FB_TLB]) run_cand[1]++;
            else close_run(1, i);
            run_cand[2]++;
          end else begin
            close_run(1, i);
            close_run(2, i);
          end
        end
        i++;
        // An exact free run ends the scan at once.
        if (run_cand[0] == need) stop = 1;
      end
      for (t = 0; t < 3; t++) close_run(t, i);
      t = 0;
      while (t < 3 && run_len[t] < need) t++;
      if (t == 3) return STAT_NO_RUN;
      for (j = run_st[t]; j < run_st[t] + need && j < m; j++) begin
        if (flags[j][FB_USE]) evicted++;
        else drop_free();
        flags[j] = MASK_USE | MASK_KER;
      end
      flags[j-1] = flags[j-1] | MASK_LAST;
      first = run_st[t];
      return STAT_OK;
    endfunction

    function logic [1:0] release_run(int unsigned idx);
      int unsigned       m;
      int unsigned       j;
      bit                found;
      logic [FLAG_W-1:0] f;
      m = span();
      if (idx >= m) return STAT_BAD_FREE;
      j     = idx;
      found = 0;
      while (j < m && !found) begin
        f = flags[j];
        if (!(f[FB_USE] && f[FB_KER])) return STAT_BAD_FREE;
        if (f[FB_LAST]) found = 1;
        else j++;
      end
      if (!found) return STAT_BAD_FREE;
      j     = idx;
      found = 0;
      while (!found) begin
        f        = flags[j];
        flags[j] = f & ~(MASK_USE | MASK_KER | MASK_LAST);
        bump_free();
        if (f[FB_LAST]) found = 1;
        j++;
      end
      return STAT_OK;
    endfunction

    function logic [1:0] write_entry(tcpa_req_t r);
      logic [FLAG_W-1:0] nf;
      logic              was;
      if (r.page_index >= span()) return STAT_BAD_REQ;
      nf = '0;
      if (r.entry_in_use) nf = nf | MASK_USE;
      if (r.entry_kernel) nf = nf | MASK_KER;
      if (r.entry_tlb)    nf = nf | MASK_TLB;
      if (r.entry_busy)   nf = nf | MASK_BUSY;
      was = flags[r.page_index][FB_USE];
      if (was && !nf[FB_USE]) bump_free();
      if (!was && nf[FB_USE]) drop_free();
      flags[r.page_index] = nf;
      return STAT_OK;
    endfunction

    // Applies one accepted request to the page map and queues its response.
    function tcpa_rsp_t note_request(tcpa_req_t r);
      tcpa_rsp_t   e;
      int unsigned first;
      int unsigned evicted;
      e       = '0;
      first   = 0;
      evicted = 0;
      case (r.opcode)
        OP_ALLOC: begin
          e.status = claim_run(r.page_count, first, evicted);
          if (e.status == STAT_OK) begin
            e.start_index   = first[IDX_W-1:0];
            e.evicted_count = evicted[CFG_W-1:0];
            n_alloc_ok++;
            n_evicted += evicted;
          end
        end
        OP_FREE: begin
          e.status = release_run(r.page_index);
          if (e.status == STAT_OK) n_free_ok++;
        end
        OP_SET: e.status = write_entry(r);
        default: e.status = STAT_BAD_REQ;
      endcase
      if (e.status != STAT_OK) n_refused++;
      e.free_pages = free_cnt[CFG_W-1:0];
      pending_rsp.push_back(e);
      return e;
    endfunction

    function int pending();
      return pending_rsp.size();
    endfunction

    task report(string what, int got, int want);
      $display("[%0t] %s: got %0d, want %0d", $time, what, got, want);
      errors++;
    endtask

    task check_response(tcpa_rsp_t got);
      tcpa_rsp_t want;
      if (pending_rsp.size() == 0) begin
        report("response with no request outstanding, status", got.status, -1);
        return;
      end
      want = pending_rsp.pop_front();
      n_checked++;
      if (got.status !== want.status) report("status", got.status, want.status);
      if (got.start_index !== want.start_index)
        report("start_index", got.start_index, want.start_index);
      if (got.evicted_count !== want.evicted_count)
        report("evicted_count", got.evicted_count, want.evicted_count);
      if (got.free_pages !== want.free_pages)
        report("free_pages", got.free_pages, want.free_pages);
    endtask
  endclass

  localparam int          PAGES          = NUM_PAGES_DEF;
  localparam int          CYCLE_LIMIT    = 4000000;
  localparam int          HOLDOFF_CYCLES = 400;
  localparam int          TAIL_CYCLES    = 50;
  localparam logic [1:0]  OP_UNUSED      = 2'd3;

  typedef enum int {RDY_ALWAYS, RDY_TWO_OF_THREE, RDY_COIN, RDY_ONE_OF_FIVE} ready_mode_t;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        req_valid = 1'b0;
  tcpa_req_t   req       = '0;
  logic        rsp_ready = 1'b0;
  logic        cfg_we    = 1'b0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic        req_ready;
  logic        rsp_valid;
  tcpa_rsp_t   rsp;

  alloc_scoreboard sb;
  int unsigned     live_runs [$];
  int              burst_left   = 0;
  int              holdoff_asks = 0;
  int              holdoff_done = 0;
  int              n_sent       = 0;
  int              n_cfg        = 0;
  int              cycles       = 0;
  bit              steady       = 0;
  ready_mode_t     ready_mode   = RDY_ALWAYS;
  int              mode_left    = 0;
  int              pat_cnt      = 0;
  int              hold_left    = 0;

  tiered_contiguous_page_allocator_top uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Timed out after %0d cycles", cycles);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Response side: checks each accepted transaction, then picks the next ready.
  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) sb.check_response(rsp);
    if (rst) begin
      rsp_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      rsp_ready <= 1'b0;
    end else if (holdoff_done != holdoff_asks) begin
      holdoff_done++;
      hold_left = HOLDOFF_CYCLES - 1;
      rsp_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        ready_mode = ready_mode_t'($urandom_range(0, 3));
        mode_left  = $urandom_range(20, 80);
      end
      mode_left--;
      pat_cnt++;
      case (ready_mode)
        RDY_ALWAYS:       rsp_ready <= 1'b1;
        RDY_TWO_OF_THREE: rsp_ready <= (pat_cnt % 3) != 0;
        RDY_COIN:         rsp_ready <= 1'($urandom_range(0, 1));
        default:          rsp_ready <= (pat_cnt % 5) == 0;
      endcase
    end
  end

  // Offers one request and returns once it is accepted; valid stays high so
  // that the next request can follow without a gap.
  task automatic send_req(input tcpa_req_t r, output tcpa_rsp_t pred);
    int gap;
    if (burst_left <= 0) begin
      gap        = (steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 10);
      if (gap > 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    req       <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    pred = sb.note_request(r);
    burst_left--;
    n_sent++;
  endtask

  task automatic issue(input tcpa_req_t r);
    tcpa_rsp_t pred;
    send_req(r, pred);
    if (r.opcode == OP_ALLOC && pred.status == STAT_OK) live_runs.push_back(pred.start_index);
  endtask

  function automatic tcpa_req_t make_req(logic [1:0] op, int unsigned idx, int unsigned cnt,
                                         logic [3:0] ent);
    tcpa_req_t r;
    r.opcode       = op;
    r.page_index   = IDX_W'(idx);
    r.page_count   = CFG_W'(cnt);
    r.entry_in_use = ent[3];
    r.entry_kernel = ent[2];
    r.entry_tlb    = ent[1];
    r.entry_busy   = ent[0];
    return r;
  endfunction

  // Holds off new requests until every outstanding response has arrived.
  task automatic drain();
    req_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() > 0);
    burst_left = 0;
  endtask

  task automatic write_managed(input logic [CFG_W-1:0] v);
    drain();
    do @(posedge clk); while (!req_ready);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.configure(v);
    n_cfg++;
  endtask

  task automatic run_random(input int count);
    tcpa_req_t   r;
    logic [31:0] raw;
    int unsigned m;
    int          k;
    int          pick;
    m = sb.span();
    for (int n = 0; n < count; n++) begin
      raw = $urandom;
      r   = raw[$bits(tcpa_req_t)-1:0];
      k   = $urandom_range(0, 99);
      if (k < 36) begin
        r.opcode = OP_ALLOC;
        pick     = $urandom_range(0, 19);
        if (pick == 0) r.page_count = '0;
        else if (pick == 1) r.page_count = CFG_W'($urandom_range(1, m));
        else if (pick == 2)
          r.page_count = CFG_W'((m + 3 > PAGES) ? PAGES : m + $urandom_range(1, 3));
        else if (pick == 3) r.page_count = CFG_W'(PAGES);
        else r.page_count = CFG_W'($urandom_range(1, (m < 6) ? m : 6));
      end else if (k < 62) begin
        // Mostly release runs that were actually granted.
        r.opcode = OP_FREE;
        if (live_runs.size() > 0) begin
          pick         = $urandom_range(0, live_runs.size() - 1);
          r.page_index = IDX_W'(live_runs[pick]);
          live_runs.delete(pick);
        end else begin
          r.page_index = IDX_W'($urandom_range(0, m - 1));
        end
      end else if (k < 66) begin
        r.opcode = OP_FREE;
      end else if (k < 90) begin
        r.opcode       = OP_SET;
        r.page_index   = IDX_W'($urandom_range(0, m - 1));
        r.entry_busy   = ($urandom_range(0, 7) == 0);
        r.entry_kernel = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 4) == 0)
          {r.entry_in_use, r.entry_kernel, r.entry_tlb, r.entry_busy} = '0;
      end else if (k < 95) begin
        r.opcode = OP_SET;
      end else begin
        r.opcode = OP_UNUSED;
      end
      issue(r);
    end
  endtask

  initial begin
    sb = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    issue(make_req(OP_ALLOC, 0, 0, 4'b0000));
    issue(make_req(OP_ALLOC, 0, PAGES, 4'b0000));
    issue(make_req(OP_ALLOC, 0, 1, 4'b0000));
    issue(make_req(OP_FREE, 1023, 0, 4'b0000));
    issue(make_req(OP_FREE, 1023, 0, 4'b0000));
    // The walk from frame 0 runs into the frame released just before.
    issue(make_req(OP_FREE, 0, 0, 4'b0000));
    issue(make_req(OP_ALLOC, 0, 1, 4'b0000));
    issue(make_req(OP_FREE, 0, 0, 4'b0000));
    issue(make_req(OP_SET, 1023, PAGES, 4'b1111));
    issue(make_req(OP_UNUSED, 1023, 1023, 4'b1111));
    issue(make_req(OP_SET, 1023, 0, 4'b0000));

    // A tiny map makes the second and third tiers reachable.
    write_managed(8);
    issue(make_req(OP_SET, 0, 0, 4'b1000));
    issue(make_req(OP_SET, 3, 0, 4'b1010));
    issue(make_req(OP_SET, 6, 0, 4'b1100));
    issue(make_req(OP_ALLOC, 0, 3, 4'b0000));
    issue(make_req(OP_ALLOC, 0, 3, 4'b0000));
    issue(make_req(OP_ALLOC, 0, 2, 4'b0000));
    issue(make_req(OP_SET, 7, 0, 4'b1100));
    issue(make_req(OP_FREE, 6, 0, 4'b0000));
    issue(make_req(OP_SET, 4, 0, 4'b0001));
    issue(make_req(OP_FREE, 3, 0, 4'b0000));
    issue(make_req(OP_ALLOC, 0, 1, 4'b0000));
    issue(make_req(OP_SET, 8, 0, 4'b1000));
    issue(make_req(OP_FREE, 9, 0, 4'b0000));
    issue(make_req(OP_FREE, 0, 0, 4'b0000));

    write_managed(64);
    run_random(60);
    write_managed(1);
    run_random(25);
    write_managed(16);
    run_random(30);
    // Let everything drain, then keep offering while responses are held off.
    drain();
    holdoff_asks++;
    run_random(30);
    write_managed(1023);
    run_random(20);
    write_managed(200);
    run_random(45);
    steady = 1;
    write_managed(5);
    run_random(30);
    steady = 0;
    write_managed(PAGES);
    run_random(25);

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Sent %0d requests across %0d managed_pages settings: %0d grants (%0d frames evicted),",
             n_sent, n_cfg + 1, sb.n_alloc_ok, sb.n_evicted);
    $display("%0d runs released, %0d requests refused; %0d responses compared, %0d mismatches.",
             sb.n_free_ok, sb.n_refused, sb.n_checked, sb.errors);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

[sim.f]
src/tcpa_pkg.sv
src/tcpa_runs.sv
src/tiered_contiguous_page_allocator_top.sv
verif/tiered_contiguous_page_allocator_top_tb.sv
